@@ design/cor_pkg.sv @@
package cor_pkg;

  // Fixed field widths of the pixel stream and of the radius arithmetic.
  localparam int PIX_W    = 14;
  localparam int RAD_W    = 11;
  localparam int SQ_W     = 2 * RAD_W;
  localparam int SQ_STEPS = RAD_W;
  localparam int CNT_W    = $clog2(SQ_STEPS);

  // Pixel index of the eighth and last pixel of a column.
  localparam logic [2:0] LAST_PIX = 3'd7;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cor_reg_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_LOAD
  } cor_state_t;

  // One column handed from the sequencer to the pixel emitter.
  typedef struct packed {
    logic [RAD_W-1:0] offset;
    logic [RAD_W-1:0] height;
    logic             fin;
  } cor_col_t;

endpackage

@@ design/cor_isqrt.sv @@
module cor_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cor_pkg::SQ_W-1:0]   radicand,
  output logic                       done,
  output logic [cor_pkg::RAD_W-1:0]  root
);

  // Restoring square root, one radicand digit pair per cycle.
  logic [cor_pkg::SQ_W-1:0]   rad_sh;
  logic [cor_pkg::RAD_W+1:0]  rem;
  logic [cor_pkg::CNT_W-1:0]  cnt;
  logic                       busy;

  logic [cor_pkg::RAD_W+3:0]  rem_sh;
  logic [cor_pkg::RAD_W+3:0]  trial;
  logic [cor_pkg::RAD_W+3:0]  diff;
  logic                       take;

  always_comb begin
    rem_sh = {rem, rad_sh[cor_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cor_pkg::CNT_W'(cor_pkg::SQ_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[cor_pkg::SQ_W-3:0], 2'b00};
      if (take) begin
        rem  <= diff[cor_pkg::RAD_W+1:0];
        root <= {root[cor_pkg::RAD_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[cor_pkg::RAD_W+1:0];
        root <= {root[cor_pkg::RAD_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/cor_emit.sv @@
module cor_emit #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  cor_pkg::cor_col_t                   col_in,
  input  logic [COORD_BITS-1:0]               center_x,
  input  logic [COORD_BITS-1:0]               center_y,
  output logic                                ready,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic signed [cor_pkg::PIX_W-1:0]    pixel_x,
  output logic signed [cor_pkg::PIX_W-1:0]    pixel_y,
  output logic                                last_pix,
  output logic                                fin
);

  localparam int EXT_W = cor_pkg::PIX_W - cor_pkg::RAD_W;

  // Per-pixel selection: bit k belongs to the k-th pixel of a column.
  localparam logic [7:0] X_USE_HEIGHT = 8'h99;
  localparam logic [7:0] X_PLUS       = 8'h3C;
  localparam logic [7:0] Y_PLUS       = 8'h0F;

  logic [cor_pkg::PIX_W-1:0] cx;
  logic [cor_pkg::PIX_W-1:0] cy;

  generate
    if (COORD_BITS >= cor_pkg::PIX_W) begin : g_trunc
      assign cx = center_x[cor_pkg::PIX_W-1:0];
      assign cy = center_y[cor_pkg::PIX_W-1:0];
    end else begin : g_ext
      assign cx = {{(cor_pkg::PIX_W-COORD_BITS){1'b0}}, center_x};
      assign cy = {{(cor_pkg::PIX_W-COORD_BITS){1'b0}}, center_y};
    end
  endgenerate

  cor_pkg::cor_col_t          col;
  cor_pkg::cor_col_t          src;
  logic [2:0]                 k;
  logic [2:0]                 ksel;
  logic [cor_pkg::PIX_W-1:0]  xd;
  logic [cor_pkg::PIX_W-1:0]  yd;
  logic [cor_pkg::PIX_W-1:0]  x_val;
  logic [cor_pkg::PIX_W-1:0]  y_val;
  logic                       advance;

  always_comb begin
    advance = m_tvalid && m_tready;
    src     = load ? col_in : col;
    ksel    = load ? 3'd0 : k + 3'd1;
    xd      = X_USE_HEIGHT[ksel] ? {{EXT_W{1'b0}}, src.height} : {{EXT_W{1'b0}}, src.offset};
    yd      = X_USE_HEIGHT[ksel] ? {{EXT_W{1'b0}}, src.offset} : {{EXT_W{1'b0}}, src.height};
    x_val   = X_PLUS[ksel] ? cx + xd : cx - xd;
    y_val   = Y_PLUS[ksel] ? cy + yd : cy - yd;
    ready   = !m_tvalid || (m_tready && (k == cor_pkg::LAST_PIX));
    last_pix = k == cor_pkg::LAST_PIX;
    fin     = col.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      k        <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      k        <= '0;
    end else if (advance) begin
      if (k == cor_pkg::LAST_PIX) begin
        m_tvalid <= 1'b0;
      end else begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load || advance) begin
      col     <= src;
      pixel_x <= x_val;
      pixel_y <= y_val;
    end
  end

endmodule

@@ design/circle_outline_rasterizer_unit.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata[0] restart
// m_        out  m_tvalid/m_tready  m_tdata pixel_x, pixel_y; m_tlast; m_tuser
// cfg_      in   cfg_we             cfg_index, cfg_data
//
// A step that draws a column passes, before its first pixel, through acceptance,
// the (r - i') * (r + i') product, the bit-serial root and the hand-over of the
// column to the emitter.
// The eight pixels of a column leave one per cycle while m_tready holds, as the next step's root runs.
// A step that draws nothing leaves the sequencer idle. Reset is synchronous on rst.
// A stall on m_tready holds the current pixel and, once the emitter is full,
// holds the finished column in the load state and the input closed.
module circle_outline_rasterizer_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [13:0] pixel_x, [27:14] pixel_y, [31:28] zero
  output logic        m_tlast,   // last_of_column
  output logic        m_tuser,   // [0] final_column
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [((COORD_BITS > cor_pkg::RAD_W) ? COORD_BITS : cor_pkg::RAD_W)-1:0] cfg_data
);

  localparam int RW = cor_pkg::RAD_W;

  // Configuration registers.
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [RW-1:0]         radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cor_pkg::REG_CENTER_X: center_x <= cfg_data[COORD_BITS-1:0];
        cor_pkg::REG_CENTER_Y: center_y <= cfg_data[COORD_BITS-1:0];
        cor_pkg::REG_RADIUS:   radius   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Drawing state: the column to draw next.
  logic [RW-1:0]  column_offset;
  logic [RW-1:0]  column_height;
  logic           drawing_active;

  cor_pkg::cor_state_t state, state_next;

  logic              accept;
  logic              restart;
  logic              mul_en;
  logic              load;
  logic              emit_ready;
  logic              sq_done;
  logic [RW-1:0]     root;
  logic [RW:0]       next_offset;
  logic [RW:0]       ni_calc;
  logic [RW:0]       r_ext;
  logic [RW:0]       r_minus;
  logic [RW:0]       r_plus;
  logic [2*RW+1:0]   product;
  logic              fin;
  cor_pkg::cor_col_t col;

  assign restart = s_tdata[0];
  assign accept  = s_tvalid && s_tready;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      cor_pkg::ST_IDLE: begin
        if (accept) begin
          if (restart) begin
            state_next = (radius != '0) ? cor_pkg::ST_MUL : cor_pkg::ST_IDLE;
          end else if (drawing_active) begin
            state_next = cor_pkg::ST_MUL;
          end
        end
      end
      cor_pkg::ST_MUL:  state_next = cor_pkg::ST_ROOT;
      cor_pkg::ST_ROOT: if (sq_done) state_next = cor_pkg::ST_LOAD;
      cor_pkg::ST_LOAD: if (emit_ready) state_next = cor_pkg::ST_IDLE;
      default:          state_next = cor_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    mul_en   = 1'b0;
    load     = 1'b0;
    case (state)
      cor_pkg::ST_IDLE: s_tready = 1'b1;
      cor_pkg::ST_MUL:  mul_en   = 1'b1;
      cor_pkg::ST_LOAD: load     = emit_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cor_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // r^2 - i'^2 is formed as (r - i') * (r + i'); it is zero once i' passes r.
  // The root unit takes the product directly at the end of the multiply cycle.
  always_comb begin
    r_ext   = {1'b0, radius};
    ni_calc = {1'b0, column_offset} + 1'b1;
    r_minus = r_ext - ni_calc;
    r_plus  = r_ext + ni_calc;
    product = (ni_calc > r_ext) ? '0 : {{(RW+1){1'b0}}, r_minus} * {{(RW+1){1'b0}}, r_plus};
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      next_offset <= ni_calc;
    end
  end

  cor_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_en),
    .radicand (product[2*RW-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  // The circle ends on the column after which the offset would pass the height.
  assign fin = next_offset > {1'b0, root};

  always_comb begin
    col.offset = column_offset;
    col.height = column_height;
    col.fin    = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset  <= '0;
      column_height  <= '0;
      drawing_active <= 1'b0;
    end else if (accept && restart) begin
      column_offset  <= '0;
      column_height  <= (radius != '0) ? radius - 1'b1 : '0;
      drawing_active <= radius != '0;
    end else if (load) begin
      if (fin) begin
        column_offset  <= '0;
        column_height  <= '0;
        drawing_active <= 1'b0;
      end else begin
        column_offset <= next_offset[RW-1:0];
        column_height <= root;
      end
    end
  end

  logic signed [cor_pkg::PIX_W-1:0] pixel_x;
  logic signed [cor_pkg::PIX_W-1:0] pixel_y;

  cor_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .col_in   (col),
    .center_x (center_x),
    .center_y (center_y),
    .ready    (emit_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .last_pix (m_tlast),
    .fin      (m_tuser)
  );

  assign m_tdata = {4'b0000, pixel_y, pixel_x};

  // An idle drawing state always points at the origin column.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !drawing_active |-> (column_offset == '0 && column_height == '0))
    else $error("idle drawing state not cleared");

  // While drawing, the next column never lies past the diagonal.
  a_offset_le_height: assert property (@(posedge clk) disable iff (rst)
    drawing_active |-> (column_offset <= column_height))
    else $error("column offset beyond column height");

  // The root unit only finishes while the sequencer waits for it.
  a_root_in_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == cor_pkg::ST_ROOT))
    else $error("root finished outside the root state");

  // A column run always starts at its first pixel.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !m_tlast)
    else $error("pixel run started at the last pixel");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_BITS     = 12;
  localparam int RAD_W          = cor_pkg::RAD_W;
  localparam int PIX_W          = cor_pkg::PIX_W;
  localparam int CFG_W          = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
  localparam int RANDOM_STEPS   = 90;
  // This drain time is ample for a drawing step to reach its first pixel.
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 500000;

  // One expected pixel transaction on the output stream.
  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
    logic             fin;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'd0;    // [0] restart, [7:1] zero
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;           // [13:0] pixel_x, [27:14] pixel_y, [31:28] zero
  logic              m_tlast;           // last_of_column
  logic              m_tuser;           // [0] final_column
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = cor_pkg::REG_CENTER_X;
  logic [CFG_W-1:0]  cfg_data = '0;

  circle_outline_rasterizer_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration as the block should see it.
  logic [COORD_BITS-1:0] set_cx = '0;
  logic [COORD_BITS-1:0] set_cy = '0;
  logic [RAD_W-1:0]      set_radius = '0;

  // Drawing state of the circle being rasterized.
  logic [RAD_W-1:0]      col_i = '0;
  logic [RAD_W-1:0]      col_h = '0;
  logic                  active = 1'b0;

  // Restart bits waiting to be sent, and pixels the block still owes us.
  logic                  step_queue[$];
  pixel_t                pixel_queue[$];
  int unsigned           steps_queued = 0;
  int unsigned           steps_taken = 0;
  int unsigned           errors = 0;
  int unsigned           cycle_count = 0;
  int                    send_gap = 0;
  int                    hold_left = 0;
  // When set, neither side of the stream inserts idle cycles.
  logic                  steady = 1'b0;

  // Mostly no idling, some short gaps and an occasional long one.
  function automatic int idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Exact integer square root, built one result bit at a time from the top.
  function automatic int unsigned int_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void add_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                                    input logic last, input logic fin);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    p.fin = fin;
    pixel_queue.push_back(p);
  endfunction

  // Advances the circle by one step and queues the eight symmetric pixels of the column,
  // if the step draws one.
  task automatic draw_column(input logic restart);
    int unsigned      r;
    int unsigned      ni;
    int unsigned      ndy;
    int unsigned      sq;
    logic             fin;
    logic [PIX_W-1:0] cxw;
    logic [PIX_W-1:0] cyw;
    logic [PIX_W-1:0] iw;
    logic [PIX_W-1:0] hw;
    r = 32'(set_radius);
    if (restart) begin
      if (r == 0) begin
        active = 1'b0;
        col_i = '0;
        col_h = '0;
        return;
      end
      col_i = '0;
      col_h = RAD_W'(r - 1);
      active = 1'b1;
    end
    if (!active) return;

    ni = int'(col_i) + 1;
    sq = (ni > r) ? 0 : r * r - ni * ni;
    ndy = int_root(sq);
    fin = (ni > ndy);

    cxw = PIX_W'(set_cx);
    cyw = PIX_W'(set_cy);
    iw = PIX_W'(col_i);
    hw = PIX_W'(col_h);
    // Octants in the block's fixed output order; the eighth pixel closes the column.
    add_pixel(cxw - hw, cyw + iw, 1'b0, fin);
    add_pixel(cxw - iw, cyw + hw, 1'b0, fin);
    add_pixel(cxw + iw, cyw + hw, 1'b0, fin);
    add_pixel(cxw + hw, cyw + iw, 1'b0, fin);
    add_pixel(cxw + hw, cyw - iw, 1'b0, fin);
    add_pixel(cxw + iw, cyw - hw, 1'b0, fin);
    add_pixel(cxw - iw, cyw - hw, 1'b0, fin);
    add_pixel(cxw - hw, cyw - iw, 1'b1, fin);

    if (fin) begin
      active = 1'b0;
      col_i = '0;
      col_h = '0;
    end else begin
      col_i = RAD_W'(ni);
      col_h = RAD_W'(ndy);
    end
  endtask

  // Stream sender. The prediction is made at the edge where a step transaction is
  // accepted, so it always uses the configuration in force at that moment.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        draw_column(s_tdata[0]);
        steps_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (step_queue.size() > 0) begin
          s_tdata <= {7'd0, step_queue.pop_front()};
          s_tvalid <= 1'b1;
          send_gap = idle_length();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel receiver. Every accepted pixel transaction is matched against the oldest
  // expected pixel; the receiver stalls for random stretches in between.
  always @(posedge clk) begin
    pixel_t seen;
    pixel_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen.x = m_tdata[PIX_W-1:0];
        seen.y = m_tdata[2*PIX_W-1:PIX_W];
        seen.last = m_tlast;
        seen.fin = m_tuser;
        if (pixel_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, actual x=%0d y=%0d last=%0b final=%0b", $time,
                   $signed(seen.x), $signed(seen.y), seen.last, seen.fin);
        end else begin
          want = pixel_queue.pop_front();
          if (seen.x !== want.x || seen.y !== want.y || seen.last !== want.last ||
              seen.fin !== want.fin) begin
            errors++;
            $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b final=%0b",
                     $time, $signed(want.x), $signed(want.y), want.last, want.fin);
            $display("%0t:                 actual   x=%0d y=%0d last=%0b final=%0b",
                     $time, $signed(seen.x), $signed(seen.y), seen.last, seen.fin);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold_left = idle_length();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input logic restart);
    step_queue.push_back(restart);
    steps_queued++;
  endtask

  // Waits until every queued step has been taken and every pixel has arrived, then gives
  // the block time to finish any step that draws nothing.
  task automatic settle();
    do @(negedge clk); while (steps_taken != steps_queued || pixel_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the shadow copy follows it, masked as the block masks it.
  task automatic write_reg(input cor_pkg::cor_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      cor_pkg::REG_CENTER_X: set_cx = value[COORD_BITS-1:0];
      cor_pkg::REG_CENTER_Y: set_cy = value[COORD_BITS-1:0];
      cor_pkg::REG_RADIUS:   set_radius = value[RAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned roll;
    int unsigned r;
    int unsigned cols;
    int unsigned ci;
    int unsigned ni;
    int unsigned adv;
    int unsigned cap;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // After reset the radius is zero: an advance while idle and a restart with zero
    // radius must both stay silent.
    send(1'b0);
    send(1'b1);
    settle();

    // Radius one at the origin: a single column that is also the last.
    // The advance that follows finds the block idle.
    write_reg(cor_pkg::REG_CENTER_X, CFG_W'(0));
    write_reg(cor_pkg::REG_CENTER_Y, CFG_W'(0));
    write_reg(cor_pkg::REG_RADIUS, CFG_W'(1));
    send(1'b1);
    send(1'b0);
    settle();

    // Largest radius at the far corner, so coordinates run past the centre range, and a
    // restart while a circle is still being drawn.
    write_reg(cor_pkg::REG_CENTER_X, CFG_W'(4095));
    write_reg(cor_pkg::REG_CENTER_Y, CFG_W'(4095));
    write_reg(cor_pkg::REG_RADIUS, CFG_W'(2047));
    send(1'b1);
    send(1'b0);
    send(1'b0);
    send(1'b0);
    send(1'b1);
    send(1'b0);
    settle();

    // A complete small circle, then two extra advances after its final column.
    write_reg(cor_pkg::REG_CENTER_X, CFG_W'(100));
    write_reg(cor_pkg::REG_CENTER_Y, CFG_W'(200));
    write_reg(cor_pkg::REG_RADIUS, CFG_W'(5));
    send(1'b1);
    repeat (4) send(1'b0);
    send(1'b0);
    settle();

    // Shrink the radius under a circle in progress: the offset after the next column exceeds the
    // new radius, so the height worked out for it is zero and the drawing ends with the next column.
    write_reg(cor_pkg::REG_RADIUS, CFG_W'(10));
    send(1'b1);
    repeat (3) send(1'b0);
    settle();
    write_reg(cor_pkg::REG_RADIUS, CFG_W'(2));
    send(1'b0);
    send(1'b0);
    settle();

    // Random part: mostly whole circles with random geometry, plus broken and noisy runs.
    while (sent < RANDOM_STEPS) begin
      steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        // Retune the radius under whatever circle is in progress and keep stepping.
        write_reg(cor_pkg::REG_RADIUS, CFG_W'($urandom_range(0, 24)));
        adv = $urandom_range(1, 3);
        repeat (adv) send(1'b0);
        sent += adv;
      end else begin
        roll = $urandom_range(0, 99);
        write_reg(cor_pkg::REG_CENTER_X,
                  CFG_W'((roll < 20) ? 0 : (roll < 40) ? 4095 : $urandom_range(0, 4095)));
        roll = $urandom_range(0, 99);
        write_reg(cor_pkg::REG_CENTER_Y,
                  CFG_W'((roll < 20) ? 0 : (roll < 40) ? 4095 : $urandom_range(0, 4095)));
        roll = $urandom_range(0, 99);
        if (roll < 70) r = $urandom_range(1, 24);
        else if (roll < 80) r = 0;
        else if (roll < 90) r = $urandom_range(25, 200);
        else r = $urandom_range(2040, 2047);
        write_reg(cor_pkg::REG_RADIUS, CFG_W'(r));

        // Number of columns the circle takes from a restart.
        cols = 0;
        if (r != 0) begin
          ci = 0;
          forever begin
            cols++;
            ni = ci + 1;
            if (ni > int_root((ni > r) ? 0 : r * r - ni * ni)) break;
            ci = ni;
          end
        end
        // Large circles are only started; a later restart abandons them.
        cap = (r > 24) ? 10 : cols;

        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send(1'b1);
          adv = (cols == 0) ? 0 : ((cols - 1 < cap) ? cols - 1 : cap);
          repeat (adv) send(1'b0);
          if ($urandom_range(0, 1) == 1) send(1'b0);
          sent += 1 + adv;
        end else if (roll < 85) begin
          send(1'b1);
          adv = $urandom_range(0, (cols < 6) ? cols : 6);
          repeat (adv) send(1'b0);
          send(1'b1);
          repeat (2) send(1'b0);
          sent += 4 + adv;
        end else begin
          adv = $urandom_range(1, 5);
          repeat (adv) send(1'($urandom_range(0, 1)));
          sent += adv;
        end
      end
      settle();
    end

    steady = 1'b0;
    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
